// ===== rtl/tst_pkg.sv =====
`default_nettype none

package tst_pkg;

	// Fixed field widths of the item and result channels
	localparam int unsigned KIND_W    = 2;
	localparam int unsigned ID_W      = 64;
	localparam int unsigned QUAL_W    = 16;
	localparam int unsigned MISS_W    = 8;
	localparam int unsigned STATUS_W  = 3;
	localparam int unsigned SLOT_W    = 5;
	localparam int unsigned COUNT_W   = 6;
	localparam int unsigned CFG_IDX_W = 1;
	localparam int unsigned CFG_W     = 16;

	// Reset values of the configuration registers and the miss count ceiling
	localparam logic [QUAL_W-1:0] QUAL_FLOOR_RST = 16'd62259;
	localparam logic [MISS_W-1:0] MISS_LIMIT_RST = 8'd100;
	localparam logic [MISS_W-1:0] MISS_MAX       = 8'd255;

	// Item kinds
	localparam logic [KIND_W-1:0] KIND_FRAME_START = 2'd0;
	localparam logic [KIND_W-1:0] KIND_DETECTION   = 2'd1;
	localparam logic [KIND_W-1:0] KIND_FRAME_END   = 2'd2;

	// Result status codes
	localparam logic [STATUS_W-1:0] ST_TICK_DONE  = 3'd0;
	localparam logic [STATUS_W-1:0] ST_IGNORED    = 3'd1;
	localparam logic [STATUS_W-1:0] ST_CREATED    = 3'd2;
	localparam logic [STATUS_W-1:0] ST_MATCHED    = 3'd3;
	localparam logic [STATUS_W-1:0] ST_TABLE_FULL = 3'd4;
	localparam logic [STATUS_W-1:0] ST_FRAME_END  = 3'd5;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_QUAL_FLOOR = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_MISS_LIMIT = 1'b1;

	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic [ID_W-1:0]   track_id;
		logic              is_stable;
		logic [QUAL_W-1:0] quality;
	} item_t;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [SLOT_W-1:0]   slot;
		logic [QUAL_W-1:0]   stored_quality;
		logic [COUNT_W-1:0]  alive_count;
		logic [COUNT_W-1:0]  evicted_count;
	} result_t;

	// Contents of one track slot
	typedef struct packed {
		logic              alive;
		logic [ID_W-1:0]   track_id;
		logic [MISS_W-1:0] miss_count;
		logic [QUAL_W-1:0] quality;
	} slot_entry_t;

	// Sequencer control toward the ring of slot cells
	typedef struct packed {
		logic        shift;
		slot_entry_t head_new;
	} ring_ctl_t;

endpackage

`default_nettype wire

// ===== rtl/tst_cell.sv =====
`default_nettype none

module tst_cell import tst_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        shift,
	input  wire slot_entry_t load_entry,
	output slot_entry_t      entry
);

	logic              alive_q;
	logic [ID_W-1:0]   id_q;
	logic [MISS_W-1:0] miss_q;
	logic [QUAL_W-1:0] qual_q;

	// Take the neighbor's slot on every shift
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alive_q <= 1'b0;
			miss_q  <= '0;
			qual_q  <= '0;
		end else if (shift) begin
			alive_q <= load_entry.alive;
			miss_q  <= load_entry.miss_count;
			qual_q  <= load_entry.quality;
		end
	end

	// Id is only looked at while the slot is live
	always_ff @(posedge clk) begin
		if (shift) begin
			id_q <= load_entry.track_id;
		end
	end

	assign entry = '{alive: alive_q, track_id: id_q, miss_count: miss_q, quality: qual_q};

endmodule

`default_nettype wire

// ===== rtl/tst_ctrl.sv =====
`default_nettype none

module tst_ctrl import tst_pkg::*; #(
	parameter int unsigned SLOTS = 32
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [CFG_W-1:0]     cfg_data,
	input  wire logic                 item_valid,
	output logic                      item_stall,
	input  wire item_t                item,
	output logic                      result_valid,
	input  wire logic                 result_stall,
	output result_t                   result,
	input  wire slot_entry_t          head,
	output ring_ctl_t                 ring_ctl
);

	localparam int unsigned IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int unsigned CNT_W = $clog2(SLOTS + 1);
	localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(SLOTS - 1);

	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_WALK = 4'b0010,
		S_FILL = 4'b0100,
		S_DONE = 4'b1000
	} state_t;

	state_t            state_q, state_d;
	item_t             item_q;
	logic [IDX_W-1:0]  idx_q, idx_d;
	logic              hit_found_q, hit_found_d;
	logic [IDX_W-1:0]  hit_idx_q, hit_idx_d;
	logic [QUAL_W-1:0] sq_q, sq_d;
	logic              free_found_q, free_found_d;
	logic [IDX_W-1:0]  free_idx_q, free_idx_d;
	logic [CNT_W-1:0]  alive_q, alive_d;
	logic [CNT_W-1:0]  evict_q, evict_d;
	logic [QUAL_W-1:0] thr_q;
	logic [MISS_W-1:0] limit_q;
	result_t           pend_q, pend_d;
	logic              pend_load;
	result_t           res_q;
	logic              res_valid_q;
	logic              accept;
	logic              res_load;
	logic [QUAL_W-1:0] new_qual;
	slot_entry_t       head_new;
	logic              last;

	assign item_stall = (state_q != S_IDLE);
	assign accept     = item_valid && !item_stall;
	assign res_load   = (state_q == S_DONE) && (!res_valid_q || !result_stall);
	assign last       = (idx_q == IDX_LAST);
	assign new_qual   = (item_q.quality >= thr_q) ? item_q.quality : '0;

	// Sequence one item over a lap (two for a new track) of the ring; ignored items skip the ring
	always_comb begin
		state_d      = state_q;
		idx_d        = idx_q;
		hit_found_d  = hit_found_q;
		hit_idx_d    = hit_idx_q;
		sq_d         = sq_q;
		free_found_d = free_found_q;
		free_idx_d   = free_idx_q;
		alive_d      = alive_q;
		evict_d      = evict_q;
		pend_d       = pend_q;
		pend_load    = 1'b0;
		head_new     = head;

		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					idx_d        = '0;
					hit_found_d  = 1'b0;
					free_found_d = 1'b0;
					evict_d      = '0;
					if (item.kind == KIND_FRAME_START || item.kind == KIND_FRAME_END ||
					    (item.kind == KIND_DETECTION && item.is_stable)) begin
						state_d = S_WALK;
					end else begin
						pend_load = 1'b1;
						pend_d    = '{status: ST_IGNORED, slot: '0, stored_quality: '0,
						              alive_count: COUNT_W'(alive_q), evicted_count: '0};
						state_d   = S_DONE;
					end
				end
			end
			S_WALK: begin
				unique case (item_q.kind)
					KIND_FRAME_START: begin
						if (head.alive && head.miss_count != MISS_MAX) begin
							head_new.miss_count = head.miss_count + MISS_W'(1);
						end
					end
					KIND_FRAME_END: begin
						if (head.alive && head.miss_count > limit_q) begin
							head_new.alive      = 1'b0;
							head_new.miss_count = '0;
							head_new.quality    = '0;
							evict_d             = evict_q + CNT_W'(1);
							alive_d             = alive_q - CNT_W'(1);
						end
					end
					KIND_DETECTION: begin
						if (head.alive && head.track_id == item_q.track_id) begin
							head_new.miss_count = '0;
							if (item_q.quality >= thr_q && item_q.quality > head.quality) begin
								head_new.quality = item_q.quality;
							end
							hit_found_d = 1'b1;
							hit_idx_d   = idx_q;
							sq_d        = head_new.quality;
						end
						if (!head.alive && !free_found_q) begin
							free_found_d = 1'b1;
							free_idx_d   = idx_q;
						end
					end
					default: begin
					end
				endcase
				idx_d = idx_q + IDX_W'(1);
				if (last) begin
					idx_d     = '0;
					pend_load = 1'b1;
					pend_d    = '{status: ST_TICK_DONE, slot: '0, stored_quality: '0,
					              alive_count: COUNT_W'(alive_d), evicted_count: '0};
					state_d   = S_DONE;
					if (item_q.kind == KIND_FRAME_END) begin
						pend_d.status        = ST_FRAME_END;
						pend_d.evicted_count = COUNT_W'(evict_d);
					end else if (item_q.kind == KIND_DETECTION) begin
						if (hit_found_d) begin
							pend_d.status         = ST_MATCHED;
							pend_d.slot           = SLOT_W'(hit_idx_d);
							pend_d.stored_quality = sq_d;
						end else if (free_found_d) begin
							pend_load = 1'b0;
							state_d   = S_FILL;
						end else begin
							pend_d.status = ST_TABLE_FULL;
						end
					end
				end
			end
			S_FILL: begin
				if (idx_q == free_idx_q) begin
					head_new = '{alive: 1'b1, track_id: item_q.track_id, miss_count: '0,
					             quality: new_qual};
					alive_d  = alive_q + CNT_W'(1);
				end
				idx_d = idx_q + IDX_W'(1);
				if (last) begin
					idx_d     = '0;
					pend_load = 1'b1;
					pend_d    = '{status: ST_CREATED, slot: SLOT_W'(free_idx_q),
					              stored_quality: new_qual, alive_count: COUNT_W'(alive_d),
					              evicted_count: '0};
					state_d   = S_DONE;
				end
			end
			S_DONE: begin
				if (res_load) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	assign ring_ctl = '{shift: (state_q == S_WALK) || (state_q == S_FILL), head_new: head_new};

	// Advance the sequencer and its lap bookkeeping
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			idx_q        <= '0;
			hit_found_q  <= 1'b0;
			free_found_q <= 1'b0;
			alive_q      <= '0;
			evict_q      <= '0;
		end else begin
			state_q      <= state_d;
			idx_q        <= idx_d;
			hit_found_q  <= hit_found_d;
			free_found_q <= free_found_d;
			alive_q      <= alive_d;
			evict_q      <= evict_d;
		end
	end

	// Hold the item and the per-lap payload
	always_ff @(posedge clk) begin
		if (accept) begin
			item_q <= item;
		end
		hit_idx_q  <= hit_idx_d;
		sq_q       <= sq_d;
		free_idx_q <= free_idx_d;
		if (pend_load) begin
			pend_q <= pend_d;
		end
	end

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q   <= QUAL_FLOOR_RST;
			limit_q <= MISS_LIMIT_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_QUAL_FLOOR: thr_q   <= cfg_data;
				REG_MISS_LIMIT: limit_q <= cfg_data[MISS_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// Output register: drop on transfer, load a finished result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (res_load) begin
			res_valid_q <= 1'b1;
		end else if (!result_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_load) begin
			res_q <= pend_q;
		end
	end

	assign result_valid = res_valid_q;
	assign result       = res_q;

endmodule

`default_nettype wire

// ===== rtl/track_slot_table.sv =====
// track_slot_table
// Keeps SLOTS track slots in a ring of cells that rotates one slot per cycle
// while an item is worked, past a single head position that the sequencer reads and updates.
// Items come in on item_valid/item_stall, one result per item goes out on
// result_valid/result_stall; a transfer happens when valid is high and stall low.
// Configuration: cfg_we writes cfg_data into register cfg_index
// (0 quality threshold, 1 miss limit); write only while the block is idle.
// Work per item: a frame start, frame end or matched detection takes one
// lap of the ring, then the result is loaded into the output register. A
// detection that creates a slot takes a second lap to reach the free slot.
// Ignored items skip the ring and go straight to the output register;
// one item is in the ring at a time.
// item_stall is high while an item is being worked. A finished result waits
// in the output register while result_stall is high; the next item is then
// accepted and worked, and its result waits until the register frees up.
// Reset empties every slot, clears counters and restores the registers to
// threshold 62259 and miss limit 100; no clearing pass is needed.
`default_nettype none

module track_slot_table import tst_pkg::*; #(
	parameter int unsigned SLOTS = 32
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [CFG_W-1:0]     cfg_data,
	input  wire logic                 item_valid,
	output logic                      item_stall,
	input  wire item_t                item,
	output logic                      result_valid,
	input  wire logic                 result_stall,
	output result_t                   result
);

	slot_entry_t entries [SLOTS];
	ring_ctl_t   ring_ctl;

	tst_ctrl #(
		.SLOTS(SLOTS)
	) u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.item_valid  (item_valid),
		.item_stall  (item_stall),
		.item        (item),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result      (result),
		.head        (entries[0]),
		.ring_ctl    (ring_ctl)
	);

	// Ring of slot cells: each takes its upper neighbor, the last takes the updated head
	for (genvar i = 0; i < SLOTS; i++) begin : g_cell
		slot_entry_t load_entry;
		if (i == SLOTS - 1) begin : g_tail
			assign load_entry = ring_ctl.head_new;
		end else begin : g_body
			assign load_entry = entries[i+1];
		end
		tst_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.shift     (ring_ctl.shift),
			.load_entry(load_entry),
			.entry     (entries[i])
		);
	end

endmodule

`default_nettype wire
